// ===== hdl/iort_pkg.sv =====
package iort_pkg;

    localparam int HOLD_DEPTH_DEF = 16;
    localparam int INDEX_BITS_DEF = 24;

    // fixed field widths at the ports
    localparam int FRAME_BITS = 24;
    localparam int COUNT_BITS = 5;
    localparam int COUNT_MAX  = 31;

    // configuration register indexes
    localparam logic REG_TRACKING = 1'b0;
    localparam logic REG_START    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RUN
    } state_t;

    // control broadcast to every cell of the store
    typedef struct packed {
        logic clear;
        logic shift;
        logic insert;
    } cell_ctrl_t;

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [31:0] v);
        logic [COUNT_BITS-1:0] r;
        if (v > 32'(COUNT_MAX))
        begin
            r = COUNT_BITS'(COUNT_MAX);
        end
        else
        begin
            r = v[COUNT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/iort_cell.sv =====
module iort_cell
    import iort_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [INDEX_BITS-1:0] idx,
    input  logic                  prev_valid,
    input  logic                  prev_lt,
    input  logic [INDEX_BITS-1:0] prev_held,
    input  logic                  next_valid,
    input  logic [INDEX_BITS-1:0] next_held,
    output logic                  valid,
    output logic [INDEX_BITS-1:0] held,
    output logic                  lt,
    output logic                  eq
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [INDEX_BITS-1:0] held_reg;
    logic [INDEX_BITS-1:0] held_next;

    assign valid = valid_reg;
    assign held  = held_reg;
    assign lt    = valid_reg && (held_reg < idx);
    assign eq    = valid_reg && (held_reg == idx);

    always_comb
    begin
        valid_next = valid_reg;
        held_next  = held_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            // advance one place toward the head
            valid_next = next_valid;
            held_next  = next_held;
        end
        else if (ctrl.insert && !lt)
        begin
            if (prev_lt)
            begin
                valid_next = 1'b1;
                held_next  = idx;
            end
            else
            begin
                valid_next = prev_valid;
                held_next  = prev_held;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// ===== hdl/in_order_release_tracker_unit.sv =====
// Takes completed frame indices in any order and reports, one result per index,
// how many frames became releasable in order. An index is accepted when start is
// high and busy is low; its result shows on the result ports for exactly one cycle
// with done high, and must be captured in that cycle. An index that releases
// nothing visits only the evaluation state, and busy is already low during the
// strobe, so a new index can be accepted during the strobe. The expected index
// goes from the evaluation state to the run state and stays there while held
// early arrivals follow it without a gap: held indices sit in a sorted row of
// cells, leaving the row's head one per cycle. Writing REG_START loads the expected
// index and empties the store; write configuration only while busy is low.
module in_order_release_tracker_unit
    import iort_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic                  wr_index,
    input  logic [FRAME_BITS-1:0] wr_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [FRAME_BITS-1:0] frame_index,
    output logic                  done,
    output logic [COUNT_BITS-1:0] release_count,
    output logic [FRAME_BITS-1:0] next_expected,
    output logic [COUNT_BITS-1:0] pending_count,
    output logic                  was_duplicate,
    output logic                  was_dropped
);

    localparam int CNT_BITS = $clog2(HOLD_DEPTH + 1);
    localparam int REL_BITS = $clog2(HOLD_DEPTH + 2);

    state_t                state_reg;
    state_t                state_next;
    logic                  enabled_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [INDEX_BITS-1:0] expected_reg;
    logic [INDEX_BITS-1:0] expected_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [REL_BITS-1:0]   released_reg;
    logic [REL_BITS-1:0]   released_next;

    logic                  done_reg;
    logic                  done_next;
    logic [COUNT_BITS-1:0] release_count_reg;
    logic [COUNT_BITS-1:0] release_count_next;
    logic [FRAME_BITS-1:0] next_expected_reg;
    logic [FRAME_BITS-1:0] next_expected_next;
    logic [COUNT_BITS-1:0] pending_count_reg;
    logic [COUNT_BITS-1:0] pending_count_next;
    logic                  dup_reg;
    logic                  dup_next;
    logic                  dropped_reg;
    logic                  dropped_next;

    cell_ctrl_t            ctrl;
    logic [HOLD_DEPTH-1:0] cell_valid;
    logic [HOLD_DEPTH-1:0] cell_lt;
    logic [HOLD_DEPTH-1:0] cell_eq;
    logic [INDEX_BITS-1:0] cell_held [HOLD_DEPTH];

    logic                  any_eq;
    logic                  full;
    logic                  head_match;

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign release_count = release_count_reg;
    assign next_expected = next_expected_reg;
    assign pending_count = pending_count_reg;
    assign was_duplicate = dup_reg;
    assign was_dropped   = dropped_reg;

    genvar k;
    generate
        for (k = 0; k < HOLD_DEPTH; k++)
        begin : g_cell
            logic                  p_valid;
            logic                  p_lt;
            logic [INDEX_BITS-1:0] p_held;
            logic                  n_valid;
            logic [INDEX_BITS-1:0] n_held;

            if (k == 0)
            begin : g_head
                assign p_valid = 1'b1;
                assign p_lt    = 1'b1;
                assign p_held  = idx_reg;
            end
            else
            begin : g_body
                assign p_valid = cell_valid[k-1];
                assign p_lt    = cell_lt[k-1];
                assign p_held  = cell_held[k-1];
            end

            if (k == HOLD_DEPTH - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_held  = '0;
            end
            else
            begin : g_inner
                assign n_valid = cell_valid[k+1];
                assign n_held  = cell_held[k+1];
            end

            iort_cell #(
                .INDEX_BITS(INDEX_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .idx       (idx_reg),
                .prev_valid(p_valid),
                .prev_lt   (p_lt),
                .prev_held (p_held),
                .next_valid(n_valid),
                .next_held (n_held),
                .valid     (cell_valid[k]),
                .held      (cell_held[k]),
                .lt        (cell_lt[k]),
                .eq        (cell_eq[k])
            );
        end
    endgenerate

    assign any_eq     = |cell_eq;
    assign full       = cell_valid[HOLD_DEPTH-1];
    assign head_match = cell_valid[0] && (cell_held[0] == expected_reg);

    always_comb
    begin
        state_next         = state_reg;
        expected_next      = expected_reg;
        count_next         = count_reg;
        released_next      = released_reg;
        ctrl               = '0;
        done_next          = 1'b0;
        release_count_next = release_count_reg;
        next_expected_next = next_expected_reg;
        pending_count_next = pending_count_reg;
        dup_next           = dup_reg;
        dropped_next       = dropped_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                done_next          = 1'b1;
                release_count_next = '0;
                next_expected_next = FRAME_BITS'(32'(expected_reg));
                pending_count_next = sat_count(32'(count_reg));
                dup_next           = 1'b0;
                dropped_next       = 1'b0;
                state_next         = ST_IDLE;
                if (enabled_reg)
                begin
                    if (idx_reg == expected_reg)
                    begin
                        // hold the result until the run is drained
                        done_next     = 1'b0;
                        expected_next = expected_reg + INDEX_BITS'(1);
                        released_next = REL_BITS'(1);
                        state_next    = ST_RUN;
                    end
                    else if (idx_reg < expected_reg || any_eq)
                    begin
                        dup_next = 1'b1;
                    end
                    else if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert        = 1'b1;
                        count_next         = count_reg + CNT_BITS'(1);
                        pending_count_next = sat_count(32'(count_reg) + 32'd1);
                    end
                end
            end
            ST_RUN:
            begin
                if (head_match)
                begin
                    ctrl.shift    = 1'b1;
                    expected_next = expected_reg + INDEX_BITS'(1);
                    released_next = released_reg + REL_BITS'(1);
                    count_next    = count_reg - CNT_BITS'(1);
                end
                else
                begin
                    done_next          = 1'b1;
                    release_count_next = sat_count(32'(released_reg));
                    next_expected_next = FRAME_BITS'(32'(expected_reg));
                    pending_count_next = sat_count(32'(count_reg));
                    dup_next           = 1'b0;
                    dropped_next       = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en && wr_index == REG_START)
        begin
            expected_next = INDEX_BITS'(wr_data);
            count_next    = '0;
            ctrl.clear    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            enabled_reg  <= 1'b0;
            expected_reg <= '0;
            count_reg    <= '0;
            released_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            expected_reg <= expected_next;
            count_reg    <= count_next;
            released_reg <= released_next;
            done_reg     <= done_next;
            if (wr_en && wr_index == REG_TRACKING)
            begin
                enabled_reg <= wr_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            idx_reg <= INDEX_BITS'(frame_index);
        end
        release_count_reg <= release_count_next;
        next_expected_reg <= next_expected_next;
        pending_count_reg <= pending_count_next;
        dup_reg           <= dup_next;
        dropped_reg       <= dropped_next;
    end

endmodule

// ===== hdl/iort_checker.sv =====
module iort_checker
    import iort_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  busy,
    input logic                  done,
    input logic [COUNT_BITS-1:0] release_count,
    input logic [COUNT_BITS-1:0] pending_count,
    input logic                  was_duplicate,
    input logic                  was_dropped
);

    // a result beat always closes the work on its item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result beat");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(pending_count) <= 32'(HOLD_DEPTH)))
        else $error("pending count beyond store depth");

    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_dropped) |-> (!was_duplicate && release_count == '0))
        else $error("dropped beat also flagged or releasing");

    a_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && release_count != '0) |-> (!was_duplicate && !was_dropped))
        else $error("releasing beat also flagged");

endmodule

bind in_order_release_tracker_unit iort_checker #(
    .HOLD_DEPTH(HOLD_DEPTH)
) u_iort_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
    import iort_pkg::*;

    typedef struct packed {
        logic [COUNT_BITS-1:0] released;
        logic [FRAME_BITS-1:0] next_idx;
        logic [COUNT_BITS-1:0] held_n;
        logic                  dup;
        logic                  dropped;
    } release_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic                  wr_index;
    logic [FRAME_BITS-1:0] wr_data;
    logic                  start;
    logic                  busy;
    logic [FRAME_BITS-1:0] frame_index;
    logic                  done;
    logic [COUNT_BITS-1:0] release_count;
    logic [FRAME_BITS-1:0] next_expected;
    logic [COUNT_BITS-1:0] pending_count;
    logic                  was_duplicate;
    logic                  was_dropped;

    // tracker state as the testbench sees it
    logic                  trk_enabled;
    logic [FRAME_BITS-1:0] expect_idx;
    logic [FRAME_BITS-1:0] early_held[$];

    release_t expected_releases[$];

    int  err_count;
    int  sent_count;
    int  random_sent;
    int  phase_count;
    int  checked_count;
    int  release_events;
    int  dup_events;
    int  drop_events;
    bit  idle_on;

    in_order_release_tracker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .start         (start),
        .busy          (busy),
        .frame_index   (frame_index),
        .done          (done),
        .release_count (release_count),
        .next_expected (next_expected),
        .pending_count (pending_count),
        .was_duplicate (was_duplicate),
        .was_dropped   (was_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 250000);
        $display("status: fail");
        $finish;
    end

    function automatic release_t advance_tracker(input logic [FRAME_BITS-1:0] idx);
        release_t r;
        int       pos;
        int       rel;
        r   = '0;
        rel = 0;
        if (trk_enabled)
        begin
            if (idx == expect_idx)
            begin
                expect_idx = expect_idx + FRAME_BITS'(1);
                rel        = 1;
                // absorb every held index that now follows without a gap
                while (early_held.size() > 0 && early_held[0] == expect_idx)
                begin
                    void'(early_held.pop_front());
                    expect_idx = expect_idx + FRAME_BITS'(1);
                    rel++;
                end
            end
            else if (idx < expect_idx)
            begin
                r.dup = 1'b1;
            end
            else
            begin
                pos = 0;
                while (pos < early_held.size() && early_held[pos] < idx)
                begin
                    pos++;
                end
                if (pos < early_held.size() && early_held[pos] == idx)
                begin
                    r.dup = 1'b1;
                end
                else if (early_held.size() >= HOLD_DEPTH_DEF)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    early_held.insert(pos, idx);
                end
            end
        end
        r.released = (rel > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(rel);
        r.next_idx = expect_idx;
        r.held_n   = (early_held.size() > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                                      : COUNT_BITS'(early_held.size());
        return r;
    endfunction

    task automatic check_field(input string what, input logic [FRAME_BITS-1:0] want,
                               input logic [FRAME_BITS-1:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        release_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_releases.size() == 0)
            begin
                err_count++;
                $display("%0t unexpected result beat: expected none actual release %0d",
                         $time, release_count);
            end
            else
            begin
                want = expected_releases.pop_front();
                check_field("release_count", FRAME_BITS'(want.released),
                            FRAME_BITS'(release_count));
                check_field("next_expected", want.next_idx, next_expected);
                check_field("pending_count", FRAME_BITS'(want.held_n),
                            FRAME_BITS'(pending_count));
                check_field("was_duplicate", FRAME_BITS'(want.dup),
                            FRAME_BITS'(was_duplicate));
                check_field("was_dropped", FRAME_BITS'(want.dropped),
                            FRAME_BITS'(was_dropped));
                checked_count++;
                if (want.released != 0)
                begin
                    release_events++;
                end
                if (want.dup)
                begin
                    dup_events++;
                end
                if (want.dropped)
                begin
                    drop_events++;
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_frame(input logic [FRAME_BITS-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        frame_index <= idx;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_releases.push_back(advance_tracker(idx));
        sent_count++;
        @(negedge clk);
    endtask

    // drain all outstanding beats so the block is idle
    task automatic settle();
        start <= 1'b0;
        while (expected_releases.size() != 0 || busy !== 1'b0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FRAME_BITS-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        if (idx == REG_TRACKING)
        begin
            trk_enabled = value[0];
        end
        else
        begin
            expect_idx = value;
            early_held.delete();
        end
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [FRAME_BITS-1:0] noise_index();
        logic [FRAME_BITS-1:0] v;
        case ($urandom_range(0, 3))
            0: v = FRAME_BITS'($urandom);
            1: v = expect_idx - FRAME_BITS'($urandom_range(1, 50));
            2: v = expect_idx + FRAME_BITS'($urandom_range(2, 400));
            default:
            begin
                if (early_held.size() > 0)
                begin
                    v = early_held[$urandom_range(0, early_held.size() - 1)];
                end
                else
                begin
                    v = expect_idx + FRAME_BITS'(1);
                end
            end
        endcase
        return v;
    endfunction

    // the next n indices from the expected one, in shuffled order, with an occasional noise index mixed in
    task automatic send_window(input int n);
        int                    order[24];
        int                    i;
        int                    j;
        int                    t;
        logic [FRAME_BITS-1:0] base;
        base = expect_idx;
        for (i = 0; i < n; i++)
        begin
            order[i] = i;
        end
        for (i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_frame(noise_index());
                random_sent++;
            end
            send_frame(base + FRAME_BITS'(order[i]));
            random_sent++;
        end
    endtask

    task automatic test_disabled();
        settle();
        send_frame(24'hFFFFFF);
    endtask

    task automatic test_in_order_release();
        settle();
        write_reg(REG_TRACKING, 24'd1);
        write_reg(REG_START, 24'd0);
        send_frame(24'd0);
        send_frame(24'd2);
        send_frame(24'd3);
        send_frame(24'd1);
        send_frame(24'd2);
    endtask

    task automatic test_wrap();
        settle();
        write_reg(REG_START, 24'hFFFFFE);
        send_frame(24'hFFFFFF);
        send_frame(24'hFFFFFE);
        send_frame(24'h000000);
    endtask

    task automatic test_full_store();
        int i;
        settle();
        write_reg(REG_START, 24'd100);
        // descending order puts every insert at the head of the store
        for (i = HOLD_DEPTH_DEF; i >= 1; i--)
        begin
            send_frame(24'd100 + FRAME_BITS'(i));
        end
        send_frame(24'd100 + FRAME_BITS'(HOLD_DEPTH_DEF + 1));
        send_frame(24'd108);
        send_frame(24'd100);
    endtask

    task automatic test_random_phases();
        int phase;
        int goal;
        int n;
        phase = 0;
        while (random_sent < 1650)
        begin
            settle();
            idle_on = ($urandom_range(0, 3) != 0);
            case (phase)
                0:
                begin
                    write_reg(REG_TRACKING, 24'd1);
                    write_reg(REG_START, 24'd0);
                end
                1: write_reg(REG_START, 24'hFFFFFF);
                2: write_reg(REG_TRACKING, 24'd0);
                3: write_reg(REG_TRACKING, 24'd1);
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: write_reg(REG_TRACKING, 24'd0);
                        1: write_reg(REG_TRACKING, 24'd1);
                        default:
                        begin
                            write_reg(REG_TRACKING, 24'd1);
                            case ($urandom_range(0, 3))
                                0: write_reg(REG_START, 24'd0);
                                1: write_reg(REG_START,
                                             24'hFFFFFF - FRAME_BITS'($urandom_range(0, 30)));
                                default: write_reg(REG_START, FRAME_BITS'($urandom));
                            endcase
                        end
                    endcase
                end
            endcase
            phase_count++;
            goal = random_sent + $urandom_range(40, 120);
            while (random_sent < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_frame(noise_index());
                    random_sent++;
                end
                else
                begin
                    // mostly short windows, now and then one long enough to fill the store
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 24)
                                                    : $urandom_range(1, 12);
                    send_window(n);
                end
            end
            phase++;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        wr_en          = 1'b0;
        wr_index       = REG_TRACKING;
        wr_data        = '0;
        start          = 1'b0;
        frame_index    = '0;
        trk_enabled    = 1'b0;
        expect_idx     = '0;
        err_count      = 0;
        sent_count     = 0;
        random_sent    = 0;
        phase_count    = 0;
        checked_count  = 0;
        release_events = 0;
        dup_events     = 0;
        drop_events    = 0;
        idle_on        = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_disabled();
        test_in_order_release();
        test_wrap();
        test_full_store();
        test_random_phases();

        settle();
        repeat (20) @(negedge clk);
        if (expected_releases.size() != 0)
        begin
            err_count++;
            $display("%0t missing results: expected %0d more actual 0", $time,
                     expected_releases.size());
        end
        $display("sent %0d frame indices over %0d random config phases, checked %0d results",
                 sent_count, phase_count, checked_count);
        $display("seen %0d releasing beats, %0d duplicates, %0d drops on a full store",
                 release_events, dup_events, drop_events);
        if (err_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
